FILE: rtl/mted_pkg.sv
// Shared types and constants of the motion and touch event detector.
// Holds the channel words, the queued job record, the register set and the state encodings.
// Depends on nothing; every other file of the block imports it.
package mted_pkg;

   // One sensor snapshot, as accepted on the request channel.
   typedef struct packed {
      logic [31:0]        now_ms;
      logic               touch_valid;
      logic               touched;
      logic [15:0]        touch_raw;
      logic               imu_valid;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
   } mted_req_type;

   // One event, as delivered on the response channel.
   typedef struct packed {
      logic [1:0]  event_kind;
      logic [15:0] event_value;
      logic [31:0] event_time;
      logic        last_of_run;
   } mted_rsp_type;

   // A classified sample, passed from the front end to the event unit.
   typedef struct packed {
      logic [31:0] now_ms;
      logic        touch_valid;
      logic        touched;
      logic [15:0] touch_raw;
      logic        imu_valid;
      logic [15:0] magnitude;
      logic [15:0] tilt;
      logic [15:0] abs_z;
   } mted_job_type;

   // Configuration register contents.
   typedef struct packed {
      logic [15:0] debounce_ms;
      logic [15:0] shake_delta_mg;
      logic [15:0] tilt_mg;
      logic [15:0] fall_z_mg;
   } mted_cfg_type;

   // Register indexes.
   localparam logic [1:0] REG_DEBOUNCE = 2'd0;
   localparam logic [1:0] REG_SHAKE    = 2'd1;
   localparam logic [1:0] REG_TILT     = 2'd2;
   localparam logic [1:0] REG_FALL     = 2'd3;

   // Register reset values.
   localparam logic [15:0] DEBOUNCE_RESET = 16'd200;
   localparam logic [15:0] SHAKE_RESET    = 16'd1500;
   localparam logic [15:0] TILT_RESET     = 16'd700;
   localparam logic [15:0] FALL_RESET     = 16'd300;

   // Event kinds; also the bit positions of the pending mask.
   localparam logic [1:0] KIND_TOUCH = 2'd0;
   localparam logic [1:0] KIND_SHAKE = 2'd1;
   localparam logic [1:0] KIND_TILT  = 2'd2;
   localparam logic [1:0] KIND_FALL  = 2'd3;

   // Iteration counts of the front end.
   localparam int unsigned SQUARE_STEPS = 3;
   localparam int unsigned ROOT_STEPS   = 16;
   localparam int unsigned STEP_BITS    = $clog2(ROOT_STEPS);

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_SQUARE,
      FRONT_ROOT,
      FRONT_PUSH
   } mted_front_state_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DECIDE,
      BACK_EMIT
   } mted_back_state_type;

   // Magnitude of a two's complement 16-bit value; -32768 maps to 32768.
   function automatic logic [15:0] abs16(input logic signed [15:0] v);
      logic [15:0] u;
      u = v;
      return v[15] ? (~u + 16'd1) : u;
   endfunction

endpackage

FILE: rtl/mted_front.sv
// Front end of the event detector: accepts a snapshot and classifies it.
// Sums the squared axes and takes a floored square root, one bit a cycle.
// Depends on mted_pkg.
module mted_front import mted_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  mted_req_type req_payload,
   output logic         push_valid,
   input  logic         push_ready,
   output mted_job_type push_job
);

   mted_front_state_type state_ff, state_in;

   logic [31:0]          now_ff, now_in;
   logic                 touch_valid_ff, touch_valid_in;
   logic                 touched_ff, touched_in;
   logic [15:0]          touch_raw_ff, touch_raw_in;
   logic                 imu_valid_ff, imu_valid_in;
   logic [15:0]          abs_x_ff, abs_x_in;
   logic [15:0]          abs_y_ff, abs_y_in;
   logic [15:0]          abs_z_ff, abs_z_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [31:0]          rem_ff, rem_in;
   logic [31:0]          root_ff, root_in;
   logic [31:0]          bit_ff, bit_in;

   logic                 accept;
   logic                 last_square;
   logic                 last_root;
   logic [15:0]          square_sel;
   logic [31:0]          square;
   logic [31:0]          trial;

   assign accept      = req_valid && req_ready;
   assign last_square = (step_ff == STEP_BITS'(SQUARE_STEPS - 1));
   assign last_root   = (step_ff == STEP_BITS'(ROOT_STEPS - 1));

   // One axis is squared per cycle.
   always_comb begin
      case (step_ff)
         STEP_BITS'(0): square_sel = abs_x_ff;
         STEP_BITS'(1): square_sel = abs_y_ff;
         default:       square_sel = abs_z_ff;
      endcase
   end

   assign square = 32'(square_sel) * 32'(square_sel);
   assign trial  = root_ff + bit_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FRONT_IDLE: begin
            if (req_valid) begin
               state_in = req_payload.imu_valid ? FRONT_SQUARE : FRONT_PUSH;
            end
         end
         FRONT_SQUARE: begin
            if (last_square) begin
               state_in = FRONT_ROOT;
            end
         end
         FRONT_ROOT: begin
            if (last_root) begin
               state_in = FRONT_PUSH;
            end
         end
         FRONT_PUSH: begin
            if (push_ready) begin
               state_in = FRONT_IDLE;
            end
         end
         default: state_in = FRONT_IDLE;
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req_ready  = 1'b0;
      push_valid = 1'b0;
      unique case (state_ff)
         FRONT_IDLE:   req_ready  = 1'b1;
         FRONT_PUSH:   push_valid = 1'b1;
         FRONT_SQUARE,
         FRONT_ROOT:   ;
         default:      ;
      endcase
   end

   // Datapath: capture, sum of squares, then the restoring square root.
   always_comb begin
      now_in         = now_ff;
      touch_valid_in = touch_valid_ff;
      touched_in     = touched_ff;
      touch_raw_in   = touch_raw_ff;
      imu_valid_in   = imu_valid_ff;
      abs_x_in       = abs_x_ff;
      abs_y_in       = abs_y_ff;
      abs_z_in       = abs_z_ff;
      step_in        = step_ff;
      rem_in         = rem_ff;
      root_in        = root_ff;
      bit_in         = bit_ff;
      if (accept) begin
         now_in         = req_payload.now_ms;
         touch_valid_in = req_payload.touch_valid;
         touched_in     = req_payload.touched;
         touch_raw_in   = req_payload.touch_raw;
         imu_valid_in   = req_payload.imu_valid;
         abs_x_in       = abs16(req_payload.accel_x);
         abs_y_in       = abs16(req_payload.accel_y);
         abs_z_in       = abs16(req_payload.accel_z);
         step_in        = '0;
         rem_in         = '0;
      end else if (state_ff == FRONT_SQUARE) begin
         rem_in = rem_ff + square;
         if (last_square) begin
            step_in = '0;
            root_in = '0;
            bit_in  = 32'd1 << 30;
         end else begin
            step_in = step_ff + STEP_BITS'(1);
         end
      end else if (state_ff == FRONT_ROOT) begin
         if (rem_ff >= trial) begin
            rem_in  = rem_ff - trial;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in  = bit_ff >> 2;
         step_in = step_ff + STEP_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff         <= now_in;
      touch_valid_ff <= touch_valid_in;
      touched_ff     <= touched_in;
      touch_raw_ff   <= touch_raw_in;
      imu_valid_ff   <= imu_valid_in;
      abs_x_ff       <= abs_x_in;
      abs_y_ff       <= abs_y_in;
      abs_z_ff       <= abs_z_in;
      step_ff        <= step_in;
      rem_ff         <= rem_in;
      root_ff        <= root_in;
      bit_ff         <= bit_in;
   end

   // Classified sample handed to the queue.
   always_comb begin
      push_job.now_ms      = now_ff;
      push_job.touch_valid = touch_valid_ff;
      push_job.touched     = touched_ff;
      push_job.touch_raw   = touch_raw_ff;
      push_job.imu_valid   = imu_valid_ff;
      push_job.magnitude   = root_ff[15:0];
      push_job.tilt        = (abs_x_ff > abs_y_ff) ? abs_x_ff : abs_y_ff;
      push_job.abs_z       = abs_z_ff;
   end

endmodule

FILE: rtl/mted_queue.sv
// Short queue of classified samples between the front end and the event unit.
// Register based; the head entry is read at the read pointer.
// Depends on mted_pkg.
module mted_queue import mted_pkg::*; #(
   parameter int unsigned DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  mted_job_type push_job,
   output logic         pop_valid,
   input  logic         pop_ready,
   output mted_job_type pop_job
);

   localparam int unsigned PTR_BITS   = $clog2(DEPTH);
   localparam int unsigned COUNT_BITS = $clog2(DEPTH + 1);

   mted_job_type          entries_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   logic                  do_push;
   logic                  do_pop;

   assign push_ready = (count_ff != COUNT_BITS'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: rtl/mted_back.sv
// Event unit of the detector: holds the debounce timers and edge history.
// Decides which events a sample fires, then sends them one word at a time through an output register.
// Depends on mted_pkg.
module mted_back import mted_pkg::*; #(
   parameter int unsigned TIME_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  mted_cfg_type cfg,
   input  logic         pop_valid,
   output logic         pop_ready,
   input  mted_job_type pop_job,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output mted_rsp_type rsp_payload
);

   mted_back_state_type  state_ff, state_in;

   mted_job_type         job_ff, job_in;
   logic [3:0]           pending_ff, pending_in;
   logic [15:0]          delta_ff, delta_in;

   logic                 prev_touched_ff, prev_touched_in;
   logic [TIME_BITS-1:0] touch_time_ff, touch_time_in;
   logic [TIME_BITS-1:0] shake_time_ff, shake_time_in;
   logic [TIME_BITS-1:0] tilt_time_ff, tilt_time_in;
   logic [TIME_BITS-1:0] fall_time_ff, fall_time_in;
   logic                 have_prev_ff, have_prev_in;
   logic                 prev_imu_ff, prev_imu_in;
   logic [15:0]          prev_mag_ff, prev_mag_in;

   logic                 out_valid_ff, out_valid_in;
   mted_rsp_type         out_ff, out_in;

   logic [TIME_BITS-1:0] now_t;
   logic [TIME_BITS-1:0] debounce_t;
   logic [TIME_BITS-1:0] touch_age, shake_age, tilt_age, fall_age;
   logic [15:0]          delta;
   logic [3:0]           fire;
   logic                 out_free;
   logic                 emit;
   logic [1:0]           emit_kind;
   logic [15:0]          emit_value;
   logic [3:0]           pending_left;

   assign now_t      = TIME_BITS'(job_ff.now_ms);
   assign debounce_t = TIME_BITS'(cfg.debounce_ms);
   assign touch_age  = now_t - touch_time_ff;
   assign shake_age  = now_t - shake_time_ff;
   assign tilt_age   = now_t - tilt_time_ff;
   assign fall_age   = now_t - fall_time_ff;

   // Magnitude change against the previous valid sample.
   assign delta = (job_ff.magnitude >= prev_mag_ff) ? job_ff.magnitude - prev_mag_ff
                                                    : prev_mag_ff - job_ff.magnitude;

   // Event conditions, each gated by its own debounce timer.
   always_comb begin
      fire = '0;
      fire[KIND_TOUCH] = job_ff.touch_valid && job_ff.touched && !prev_touched_ff
                         && (touch_age >= debounce_t);
      fire[KIND_SHAKE] = job_ff.imu_valid && have_prev_ff && prev_imu_ff
                         && (delta >= cfg.shake_delta_mg) && (shake_age >= debounce_t);
      fire[KIND_TILT]  = job_ff.imu_valid && (job_ff.tilt >= cfg.tilt_mg)
                         && (tilt_age >= debounce_t);
      fire[KIND_FALL]  = job_ff.imu_valid && (job_ff.abs_z <= cfg.fall_z_mg)
                         && (fall_age >= debounce_t);
   end

   // Lowest pending kind goes out first.
   always_comb begin
      emit_kind    = KIND_FALL;
      emit_value   = job_ff.abs_z;
      pending_left = pending_ff;
      if (pending_ff[KIND_TOUCH]) begin
         emit_kind  = KIND_TOUCH;
         emit_value = job_ff.touch_raw;
      end else if (pending_ff[KIND_SHAKE]) begin
         emit_kind  = KIND_SHAKE;
         emit_value = delta_ff;
      end else if (pending_ff[KIND_TILT]) begin
         emit_kind  = KIND_TILT;
         emit_value = job_ff.tilt;
      end
      pending_left[emit_kind] = 1'b0;
   end

   assign out_free = !out_valid_ff || rsp_ready;
   assign emit     = (state_ff == BACK_EMIT) && out_free;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (pop_valid) begin
               state_in = BACK_DECIDE;
            end
         end
         BACK_DECIDE: begin
            state_in = (fire != '0) ? BACK_EMIT : BACK_IDLE;
         end
         BACK_EMIT: begin
            if (out_free && (pending_left == '0)) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // Handshake outputs.
   always_comb begin
      pop_ready = 1'b0;
      unique case (state_ff)
         BACK_IDLE:   pop_ready = 1'b1;
         BACK_DECIDE,
         BACK_EMIT:   ;
         default:     ;
      endcase
   end

   // Sample capture, history update and event emission.
   always_comb begin
      job_in          = job_ff;
      pending_in      = pending_ff;
      delta_in        = delta_ff;
      prev_touched_in = prev_touched_ff;
      touch_time_in   = touch_time_ff;
      shake_time_in   = shake_time_ff;
      tilt_time_in    = tilt_time_ff;
      fall_time_in    = fall_time_ff;
      have_prev_in    = have_prev_ff;
      prev_imu_in     = prev_imu_ff;
      prev_mag_in     = prev_mag_ff;
      out_in          = out_ff;
      out_valid_in    = out_valid_ff;

      if ((state_ff == BACK_IDLE) && pop_valid) begin
         job_in = pop_job;
      end

      if (state_ff == BACK_DECIDE) begin
         pending_in = fire;
         delta_in   = delta;
         if (fire[KIND_TOUCH]) touch_time_in = now_t;
         if (fire[KIND_SHAKE]) shake_time_in = now_t;
         if (fire[KIND_TILT])  tilt_time_in  = now_t;
         if (fire[KIND_FALL])  fall_time_in  = now_t;
         if (job_ff.touch_valid) begin
            prev_touched_in = job_ff.touched;
         end
         if (job_ff.imu_valid) begin
            prev_mag_in = job_ff.magnitude;
         end
         prev_imu_in  = job_ff.imu_valid;
         have_prev_in = 1'b1;
      end

      if (emit) begin
         pending_in              = pending_left;
         out_in.event_kind       = emit_kind;
         out_in.event_value      = emit_value;
         out_in.event_time       = job_ff.now_ms;
         out_in.last_of_run      = (pending_left == '0);
         out_valid_in            = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= BACK_IDLE;
         pending_ff      <= '0;
         prev_touched_ff <= 1'b0;
         touch_time_ff   <= '0;
         shake_time_ff   <= '0;
         tilt_time_ff    <= '0;
         fall_time_ff    <= '0;
         have_prev_ff    <= 1'b0;
         prev_imu_ff     <= 1'b0;
         prev_mag_ff     <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         pending_ff      <= pending_in;
         prev_touched_ff <= prev_touched_in;
         touch_time_ff   <= touch_time_in;
         shake_time_ff   <= shake_time_in;
         tilt_time_ff    <= tilt_time_in;
         fall_time_ff    <= fall_time_in;
         have_prev_ff    <= have_prev_in;
         prev_imu_ff     <= prev_imu_in;
         prev_mag_ff     <= prev_mag_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      delta_ff <= delta_in;
      out_ff   <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

FILE: rtl/motion_touch_event_detector.sv
// Channel  Direction  Handshake                        Word
// req      in         req_valid / req_ready            mted_req_type sensor snapshot
// rsp      out        rsp_valid / rsp_ready            mted_rsp_type event
// csr      in/out     csr_psel, csr_penable, csr_pready  four 16-bit registers at 4*i
//
// In the front end a word with acceleration passes capture, squares of the three axes,
// sixteen square root steps and a push; the square root loop sets the rate. A touch-only
// word goes from capture to the push. The event unit captures and decides each sample,
// then emits its events in turn. Reset is synchronous and clears all timers and history.
// A stalled response holds its word; the queue lets the front end keep working meanwhile.
// Depends on mted_pkg, mted_front, mted_queue and mted_back.
module motion_touch_event_detector import mted_pkg::*; #(
   parameter int unsigned TIME_BITS   = 32,
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  mted_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output mted_rsp_type rsp_payload,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   mted_cfg_type cfg_ff, cfg_in;
   logic         csr_write;
   logic [1:0]   csr_index;

   logic         push_valid, push_ready;
   mted_job_type push_job;
   logic         pop_valid, pop_ready;
   mted_job_type pop_job;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_DEBOUNCE: cfg_in.debounce_ms    = csr_pwdata[15:0];
            REG_SHAKE:    cfg_in.shake_delta_mg = csr_pwdata[15:0];
            REG_TILT:     cfg_in.tilt_mg        = csr_pwdata[15:0];
            REG_FALL:     cfg_in.fall_z_mg      = csr_pwdata[15:0];
            default:      ;
         endcase
      end
   end

   // Register read back.
   always_comb begin
      unique case (csr_index)
         REG_DEBOUNCE: csr_prdata = {16'd0, cfg_ff.debounce_ms};
         REG_SHAKE:    csr_prdata = {16'd0, cfg_ff.shake_delta_mg};
         REG_TILT:     csr_prdata = {16'd0, cfg_ff.tilt_mg};
         REG_FALL:     csr_prdata = {16'd0, cfg_ff.fall_z_mg};
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms    <= DEBOUNCE_RESET;
         cfg_ff.shake_delta_mg <= SHAKE_RESET;
         cfg_ff.tilt_mg        <= TILT_RESET;
         cfg_ff.fall_z_mg      <= FALL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mted_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_job    (push_job)
   );

   mted_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   mted_back #(
      .TIME_BITS (TIME_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_job     (pop_job),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: rtl/mted_checker.sv
// Port level checks of the motion and touch event detector, bound to its top level.
// Watches the request, response and register port handshakes over time.
// Depends on mted_pkg and motion_touch_event_detector.
module mted_checker import mted_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input mted_rsp_type rsp_payload,
   input logic         csr_pready
);

   // A stalled event word holds still.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled event word changed or dropped");

   // Reset leaves no event word on the response side.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("event word present right after reset");

   // The front end works on one sample at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("front end took a second sample without working the first");

   // Fall is the last kind in a run, so it always closes the run.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.event_kind == KIND_FALL) |-> rsp_payload.last_of_run)
      else $error("fall event not marked as last of its run");

   // The register port never inserts wait states.
   assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("register port stalled");

endmodule

bind motion_touch_event_detector mted_checker u_checker (.*);
